// ===== sv/bai_pkg.sv =====
// ----------------------------------------------------------------------------
// bai_pkg: shared types and constants for the bitmap ID allocator
// Fixed field widths, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package bai_pkg;

  localparam int unsigned MAX_IDS       = 1024;
  localparam int unsigned ID_W          = 10;
  localparam int unsigned HW_W          = 11;
  localparam int unsigned CFG_W         = 5;
  localparam int unsigned DEF_WORD_BITS = 64;
  localparam logic [CFG_W-1:0] CAP_WORDS_RESET = 5'd16;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_HINT   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_FREE   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== sv/bai_bitmap_mem.sv =====
// ----------------------------------------------------------------------------
// bai_bitmap_mem: used-bit bitmap storage
// One write port, one registered read port; per-word valid bits make
// unwritten words read as all zeros right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bai_bitmap_mem #(
  parameter int unsigned WORD_BITS = bai_pkg::DEF_WORD_BITS,
  parameter int unsigned NUM_WORDS = bai_pkg::MAX_IDS / bai_pkg::DEF_WORD_BITS,
  localparam int unsigned AW = $clog2(NUM_WORDS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [AW-1:0]        rd_addr,
  output logic      [WORD_BITS-1:0] rd_data,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

`default_nettype wire

// ===== sv/bai_ffz.sv =====
// ----------------------------------------------------------------------------
// bai_ffz: find first zero
// Returns the position of the lowest clear bit of a bitmap word.
// ----------------------------------------------------------------------------
`default_nettype none

module bai_ffz #(
  parameter int unsigned WORD_BITS = bai_pkg::DEF_WORD_BITS,
  localparam int unsigned IDX_W = $clog2(WORD_BITS)
) (
  input  wire logic [WORD_BITS-1:0] word,
  output logic                      found,
  output logic      [IDX_W-1:0]     index
);

  assign found = ~&word;

  always_comb begin
    index = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        index = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/bitmap_id_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_id_allocator_unit: bitmap ID allocator with next-fit hint
// Allocates and frees IDs from a used-bit bitmap under a small sequencer.
// ----------------------------------------------------------------------------
// Raise start for one transaction while busy is low. A free of an ID inside
// the capacity passes through the free and finish states, and an allocate
// that hits the hint through the hint and finish states; a free of an ID at
// or beyond the capacity goes straight to the finish state. An allocate that
// misses scans one bitmap word per cycle from word 0 through the single read
// port of the bitmap, stopping at the first word with a clear bit or at the
// last word in use. The result appears for exactly one cycle with done high
// in the first cycle that busy is low again; it cannot be held off, so
// capture it then. A new transaction may start in that same cycle. The
// bitmap is clear right after reset with no clearing pass. WORD_BITS must be
// a power of two. Write capacity_words only while idle; cfg_ready is always
// high.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_id_allocator_unit #(
  parameter int unsigned WORD_BITS = bai_pkg::DEF_WORD_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        operation,
  input  wire logic [bai_pkg::ID_W-1:0]    free_id,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bai_pkg::CFG_W-1:0]   cfg_data,
  output logic                             done,
  output logic      [bai_pkg::ID_W-1:0]    granted_id,
  output logic      [1:0]                  status,
  output logic      [bai_pkg::HW_W-1:0]    high_water
);

  import bai_pkg::*;

  localparam int unsigned NUM_WORDS = MAX_IDS / WORD_BITS;
  localparam int unsigned WB_LOG    = $clog2(WORD_BITS);
  localparam int unsigned WADDR_W   = $clog2(NUM_WORDS);
  localparam int unsigned WCNT_W    = WADDR_W + 1;

  state_t               state, state_next;
  logic [CFG_W-1:0]     capacity_words;
  logic [ID_W-1:0]      next_hint;
  logic [HW_W-1:0]      high_water_mark;

  op_t                  op_reg;
  logic [ID_W-1:0]      id_reg;
  logic [WCNT_W-1:0]    scan_idx;
  logic [ID_W-1:0]      res_id;
  status_t              res_status;
  status_t              status_q;

  logic [WCNT_W-1:0]    words;
  logic [HW_W-1:0]      cap;
  logic                 hint_in_cap;
  logic                 free_in_cap;
  logic [WCNT_W-1:0]    scan_next;
  logic                 scan_last;
  logic [WORD_BITS-1:0] hint_mask;
  logic [WORD_BITS-1:0] id_mask;
  logic [WORD_BITS-1:0] ffz_mask;
  logic                 hint_free;
  logic                 id_used;
  logic [HW_W-1:0]      res_id_inc;

  logic [WADDR_W-1:0]   rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [WADDR_W-1:0]   wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 ffz_found;
  logic [WB_LOG-1:0]    ffz_index;

  // effective word count, clamped to 1 .. NUM_WORDS
  always_comb begin
    if (capacity_words == '0) begin
      words = WCNT_W'(1);
    end else if (int'(capacity_words) > int'(NUM_WORDS)) begin
      words = WCNT_W'(NUM_WORDS);
    end else begin
      words = WCNT_W'(capacity_words);
    end
  end

  assign cap         = HW_W'(words) << WB_LOG;
  assign hint_in_cap = {1'b0, next_hint} < cap;
  assign free_in_cap = {1'b0, free_id} < cap;
  assign scan_next   = scan_idx + 1'b1;
  assign scan_last   = scan_next >= words;
  assign hint_mask   = {{(WORD_BITS-1){1'b0}}, 1'b1} << next_hint[WB_LOG-1:0];
  assign id_mask     = {{(WORD_BITS-1){1'b0}}, 1'b1} << id_reg[WB_LOG-1:0];
  assign ffz_mask    = {{(WORD_BITS-1){1'b0}}, 1'b1} << ffz_index;
  assign hint_free   = hint_in_cap && ((rd_data & hint_mask) == '0);
  assign id_used     = (rd_data & id_mask) != '0;
  assign res_id_inc  = {1'b0, res_id} + 1'b1;

  bai_bitmap_mem #(
    .WORD_BITS (WORD_BITS),
    .NUM_WORDS (NUM_WORDS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bai_ffz #(
    .WORD_BITS (WORD_BITS)
  ) u_ffz (
    .word  (rd_data),
    .found (ffz_found),
    .index (ffz_index)
  );

  // bitmap port control
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        rd_addr = (operation == OP_FREE) ? free_id[ID_W-1:WB_LOG]
                                         : next_hint[ID_W-1:WB_LOG];
      end
      S_HINT: begin
        rd_addr = '0;
        if (hint_free) begin
          wr_en   = 1'b1;
          wr_addr = next_hint[ID_W-1:WB_LOG];
          wr_data = rd_data | hint_mask;
        end
      end
      S_SCAN: begin
        rd_addr = scan_next[WADDR_W-1:0];
        if (ffz_found) begin
          wr_en   = 1'b1;
          wr_addr = scan_idx[WADDR_W-1:0];
          wr_data = rd_data | ffz_mask;
        end
      end
      S_FREE: begin
        if (id_used) begin
          wr_en   = 1'b1;
          wr_addr = id_reg[ID_W-1:WB_LOG];
          wr_data = rd_data & ~id_mask;
        end
      end
      S_FINISH: begin
        rd_addr = '0;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (operation == OP_ALLOC) begin
            state_next = S_HINT;
          end else if (free_in_cap) begin
            state_next = S_FREE;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_HINT:   state_next = hint_free ? S_FINISH : S_SCAN;
      S_SCAN:   state_next = (ffz_found || scan_last) ? S_FINISH : S_SCAN;
      S_FREE:   state_next = S_FINISH;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      done            <= 1'b0;
      capacity_words  <= CAP_WORDS_RESET;
      next_hint       <= '0;
      high_water_mark <= '0;
    end else begin
      state <= state_next;
      done  <= (state == S_FINISH);
      if (cfg_valid && cfg_ready) begin
        capacity_words <= cfg_data;
      end
      if (state == S_FINISH) begin
        priority if (res_status == ST_FULL) begin
          next_hint <= '0;
        end else if (res_status == ST_OK && op_reg == OP_FREE) begin
          next_hint <= res_id;
        end else if (res_status == ST_OK) begin
          next_hint <= (res_id_inc >= cap) ? '0 : res_id_inc[ID_W-1:0];
          if ({1'b0, res_id} >= high_water_mark) begin
            high_water_mark <= res_id_inc;
          end
        end else begin
          next_hint <= next_hint;
        end
      end
    end
  end

  // transaction payload
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op_reg     <= op_t'(operation);
        id_reg     <= free_id;
        res_id     <= free_id;
        res_status <= ST_BAD_FREE;
      end
      S_HINT: begin
        scan_idx   <= '0;
        res_id     <= next_hint;
        res_status <= ST_OK;
      end
      S_SCAN: begin
        scan_idx <= scan_next;
        if (ffz_found) begin
          res_id     <= {scan_idx[WADDR_W-1:0], ffz_index};
          res_status <= ST_OK;
        end else begin
          res_id     <= '0;
          res_status <= ST_FULL;
        end
      end
      S_FREE: begin
        res_status <= id_used ? ST_OK : ST_BAD_FREE;
      end
      S_FINISH: begin
        granted_id <= res_id;
        status_q   <= res_status;
      end
      default: begin
        res_status <= ST_BAD_FREE;
      end
    endcase
  end

  assign busy       = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign status     = status_q;
  assign high_water = high_water_mark;

endmodule

`default_nettype wire
